// File: design/bpdc_pkg.sv
// Shared types, constants and register indexes for the button press duration classifier.
`timescale 1ns / 1ps

package bpdc_pkg;

   // Width of the held-duration counter.
   localparam int CountWidth    = 16;
   localparam int PeriodWidth   = 8;
   localparam int ThreshWidth   = 16;
   localparam int CsrDataWidth  = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CmpWidth      = (CountWidth > ThreshWidth) ? CountWidth : ThreshWidth;

   typedef logic [CountWidth-1:0]    count_type;
   typedef logic [PeriodWidth-1:0]   period_type;
   typedef logic [ThreshWidth-1:0]   thresh_type;
   typedef logic [CsrDataWidth-1:0]  csr_data_type;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;
   typedef logic [1:0]               press_type;

   // Press classes; also used as the event codes on the result channel.
   localparam press_type ClassIdle   = 2'd0;
   localparam press_type ClassShort  = 2'd1;
   localparam press_type ClassMedium = 2'd2;
   localparam press_type ClassLong   = 2'd3;

   // Register indexes.
   localparam csr_index_type CsrSamplePeriod    = 2'd0;
   localparam csr_index_type CsrMediumThreshold = 2'd1;
   localparam csr_index_type CsrLongThreshold   = 2'd2;

   // Register reset values.
   localparam period_type ResetSamplePeriod    = 8'd5;
   localparam thresh_type ResetMediumThreshold = 16'd500;
   localparam thresh_type ResetLongThreshold   = 16'd1000;

   // One result word on its way to the output buffer.
   typedef struct packed {
      logic      valid;
      press_type press_event;
   } result_type;

endpackage

// File: design/bpdc_core.sv
// Configuration registers, sample counter, duration counter and press state machine.
`timescale 1ns / 1ps

module bpdc_core
   import bpdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wr_data,
   input  logic          accept,
   input  logic          pin_level,
   output result_type    result
);

   period_type sample_period_ff;
   thresh_type medium_threshold_ff;
   thresh_type long_threshold_ff;

   period_type sample_count_ff, sample_count_in;
   count_type  held_ticks_ff, held_ticks_in;
   press_type  press_class_ff, press_class_in;

   logic       pressed;
   logic       examine;
   period_type last_count;
   count_type  held_next;
   press_type  press_event;
   logic       reach_medium;
   logic       reach_long;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff    <= ResetSamplePeriod;
         medium_threshold_ff <= ResetMediumThreshold;
         long_threshold_ff   <= ResetLongThreshold;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CsrSamplePeriod:    sample_period_ff    <= csr_wr_data[PeriodWidth-1:0];
            CsrMediumThreshold: medium_threshold_ff <= csr_wr_data[ThreshWidth-1:0];
            CsrLongThreshold:   long_threshold_ff   <= csr_wr_data[ThreshWidth-1:0];
            default: ;
         endcase
      end
   end

   assign pressed    = ~pin_level;
   // A period of zero wraps to 255, so the pin is then examined every 256 ticks.
   assign last_count = sample_period_ff - PeriodWidth'(1);
   assign examine    = (sample_count_ff == last_count);
   assign held_next  = (held_ticks_ff == {CountWidth{1'b1}}) ? held_ticks_ff
                                                              : held_ticks_ff + CountWidth'(1);
   assign reach_medium = CmpWidth'(held_next) >= CmpWidth'(medium_threshold_ff);
   assign reach_long   = CmpWidth'(held_next) >= CmpWidth'(long_threshold_ff);

   always_comb begin
      sample_count_in = examine ? '0 : sample_count_ff + PeriodWidth'(1);
      held_ticks_in   = held_next;
      press_class_in  = press_class_ff;
      press_event     = ClassIdle;
      if (examine) begin
         unique case (press_class_ff)
            ClassIdle: begin
               if (pressed) begin
                  press_class_in = ClassShort;
                  held_ticks_in  = '0;
               end
            end
            ClassShort: begin
               if (!pressed) begin
                  press_class_in = ClassIdle;
                  press_event    = ClassShort;
               end else if (reach_medium) begin
                  press_class_in = ClassMedium;
               end
            end
            ClassMedium: begin
               if (!pressed) begin
                  press_class_in = ClassIdle;
                  press_event    = ClassMedium;
               end else if (reach_long) begin
                  press_class_in = ClassLong;
               end
            end
            default: begin
               if (!pressed) begin
                  press_class_in = ClassIdle;
                  press_event    = ClassLong;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
         held_ticks_ff   <= '0;
         press_class_ff  <= ClassIdle;
      end else if (accept) begin
         sample_count_ff <= sample_count_in;
         held_ticks_ff   <= held_ticks_in;
         press_class_ff  <= press_class_in;
      end
   end

   assign result.valid       = accept;
   assign result.press_event = press_event;

   // Off the sample tick no event may come out.
   a_no_event_between_samples: assert property (@(posedge clock) disable iff (reset)
      (accept && !examine) |-> (press_event == ClassIdle))
      else $error("event reported on a tick that does not examine the pin");

   // A reported release always returns the machine to idle.
   a_event_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && press_event != ClassIdle) |=> (press_class_ff == ClassIdle))
      else $error("state not idle after a release event");

   // The held counter never wraps back to zero except on a new press.
   a_held_saturates: assert property (@(posedge clock) disable iff (reset)
      (accept && held_ticks_ff == {CountWidth{1'b1}} && press_class_ff != ClassIdle)
      |=> (held_ticks_ff == {CountWidth{1'b1}}))
      else $error("held counter wrapped during a press");

endmodule

// File: design/bpdc_outbuf.sv
// Two-entry output buffer that lets a new word in while a result waits.
`timescale 1ns / 1ps

module bpdc_outbuf
   import bpdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type result,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output press_type  rsp_press_event
);

   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   press_type out_data_ff, out_data_in;
   press_type skid_data_ff;
   logic      out_take;
   logic      out_free;

   assign out_take = out_valid_ff && !rsp_stall;
   assign out_free = !out_valid_ff || out_take;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      if (out_free) begin
         out_valid_in  = skid_valid_ff || result.valid;
         out_data_in   = skid_valid_ff ? skid_data_ff : result.press_event;
         skid_valid_in = 1'b0;
      end else if (result.valid) begin
         // The output word is stalled: park the new word in the skid entry.
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
      if (!out_free && result.valid) begin
         skid_data_ff <= result.press_event;
      end
   end

   assign full            = skid_valid_ff;
   assign rsp_valid       = out_valid_ff;
   assign rsp_press_event = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a word while the output is empty");

   a_no_write_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !result.valid)
      else $error("word written while the buffer is full");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && out_take) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid word lost or not moved forward");

endmodule

// File: design/button_press_duration_classifier.sv
// Top level of the button press duration classifier.
`timescale 1ns / 1ps

// Usage: each word on the req_ channel is one tick carrying the raw,
// active-low pin level. Every accepted tick yields exactly one word on the
// rsp_ channel: 0 for none, or the class (short, medium, long) of a press
// that was released at this debounce sample.
// The pin is examined every sample_period ticks; the held-duration counter
// runs on every accepted tick and saturates.
// The result word is registered in the output buffer before rsp_valid.
// Throughput is one tick per cycle while req_stall is low: the state update
// is a single pass of logic between the state registers and the output register.
// A two-entry output buffer decouples the channels; req_stall rises only when
// the result word is stalled and a second word is already parked behind it,
// and it is driven straight from a register.
// A stalled result word holds its value until taken.
// Reset (synchronous, active high) loads the register defaults (period 5,
// thresholds 500 and 1000), clears the counters, returns the press machine to
// idle and empties the output buffer. The user writes registers through csr_
// only while the block is idle (not enforced by it); unused-index writes are ignored.

module button_press_duration_classifier
   import bpdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  csr_index_type csr_index,
   input  csr_data_type  csr_wr_data,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          req_pin_level,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output press_type     rsp_press_event
);

   logic       accept;
   logic       buf_full;
   result_type result;

   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   bpdc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .pin_level   (req_pin_level),
      .result      (result)
   );

   bpdc_outbuf u_outbuf (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .full            (buf_full),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_press_event (rsp_press_event)
   );

endmodule
